[rtl/core/mfe_pkg.sv]
package mfe_pkg;

    localparam logic [16:0] MAX_VERTICES   = 17'd65536;
    localparam logic [18:0] MAX_FACE_WORDS = 19'd262144;
    localparam logic [16:0] MAX_COLORS     = 17'd65536;
    localparam logic [3:0]  UNITS_MAX      = 4'd8;

    localparam logic [31:0] CRC_POLY        = 32'hEDB88320;
    localparam logic [31:0] CRC_ALL         = 32'hFFFFFFFF;
    localparam logic [31:0] MAGIC_WORD      = 32'h4F454753;
    localparam logic [7:0]  FORMAT_VERSION  = 8'd1;
    localparam logic [7:0]  FLAG_COLORS     = 8'h40;
    localparam logic [21:0] COUNT_WORD_OFF  = 22'd16;
    localparam logic [21:0] HEADER_LO_OFF   = 22'd0;
    localparam logic [21:0] HEADER_HI_OFF   = 22'd8;
    localparam logic [21:0] BODY_DATA_START = 22'd24;
    localparam logic [3:0]  BYTES_WIDE      = 4'd8;
    localparam logic [3:0]  BYTES_NARROW    = 4'd4;
    localparam logic [3:0]  BYTES_NONE      = 4'd0;

    localparam logic [1:0] CFG_VERTEX_TRIPLES   = 2'd0;
    localparam logic [1:0] CFG_FACE_WORD_COUNT  = 2'd1;
    localparam logic [1:0] CFG_COLOR_WORD_COUNT = 2'd2;
    localparam logic [1:0] CFG_UNITS_CODE       = 2'd3;

    localparam logic FUNC_DATA  = 1'b0;
    localparam logic FUNC_CLOSE = 1'b1;

    typedef enum logic [1:0] {
        SEC_VERT  = 2'd0,
        SEC_FACE  = 2'd1,
        SEC_COLOR = 2'd2,
        SEC_DONE  = 2'd3
    } t_sec;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DROP  = 2'd1,
        ST_SHORT = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        BEAT_CW = 2'd0,
        BEAT_H0 = 2'd1,
        BEAT_H1 = 2'd2
    } t_beat;

    typedef struct packed {
        logic        func;
        logic [63:0] data_word;
    } t_in_item;

    typedef struct packed {
        logic [21:0] byte_offset;
        logic [63:0] out_data;
        logic [3:0]  byte_count;
        logic        last;
        logic [1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic [16:0] vertex_triples;
        logic [18:0] face_word_count;
        logic [16:0] color_word_count;
        logic [3:0]  units_code;
    } t_cfg;

    typedef struct packed {
        logic        is_close;
        logic [21:0] byte_offset;
        logic [63:0] out_data;
        logic [3:0]  byte_count;
        t_status     status;
        logic        has_colors;
        logic [3:0]  units_code;
        logic [31:0] crc;
    } t_res;

    typedef struct packed {
        t_sec        sec;
        logic [18:0] rem;
    } t_sec_pos;

    function automatic logic [31:0] crc_fold64(input logic [31:0] c, input logic [63:0] d);
        logic [31:0] x;
        x = c;
        for (int i = 0; i < 64; i++) begin
            x = (x[0] ^ d[i]) ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

    function automatic logic [31:0] crc_fold32(input logic [31:0] c, input logic [31:0] d);
        logic [31:0] x;
        x = c;
        for (int i = 0; i < 32; i++) begin
            x = (x[0] ^ d[i]) ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

    // skip over sections that are empty
    function automatic t_sec_pos settle(input t_sec s, input logic [18:0] r,
                                        input logic [18:0] f, input logic [16:0] c);
        t_sec_pos p;
        p.sec = s;
        p.rem = r;
        for (int k = 0; k < 3; k++) begin
            if (p.rem == 19'd0) begin
                unique case (p.sec)
                    SEC_VERT: begin
                        p.sec = SEC_FACE;
                        p.rem = f;
                    end
                    SEC_FACE: begin
                        p.sec = SEC_COLOR;
                        p.rem = {2'b00, c};
                    end
                    SEC_COLOR: begin
                        p.sec = SEC_DONE;
                    end
                    SEC_DONE: begin
                        p.sec = SEC_DONE;
                    end
                endcase
            end
        end
        return p;
    endfunction

endpackage

[rtl/core/mfe_cfg_regs.sv]
module mfe_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [18:0]   i_cfg_data,
    output mfe_pkg::t_cfg o_cfg
);

    logic [16:0] r_vert;
    logic [18:0] r_face;
    logic [16:0] r_color;
    logic [3:0]  r_units;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vert  <= '0;
            r_face  <= '0;
            r_color <= '0;
            r_units <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mfe_pkg::CFG_VERTEX_TRIPLES:   r_vert  <= i_cfg_data[16:0];
                mfe_pkg::CFG_FACE_WORD_COUNT:  r_face  <= i_cfg_data;
                mfe_pkg::CFG_COLOR_WORD_COUNT: r_color <= i_cfg_data[16:0];
                mfe_pkg::CFG_UNITS_CODE:       r_units <= i_cfg_data[3:0];
            endcase
        end
    end

    // saturate counts, units codes above UNITS_MAX become code 0
    always_comb begin
        o_cfg.vertex_triples   = (r_vert > mfe_pkg::MAX_VERTICES) ? mfe_pkg::MAX_VERTICES : r_vert;
        o_cfg.face_word_count  = (r_face > mfe_pkg::MAX_FACE_WORDS) ?
                                 mfe_pkg::MAX_FACE_WORDS : r_face;
        o_cfg.color_word_count = (r_color > mfe_pkg::MAX_COLORS) ? mfe_pkg::MAX_COLORS : r_color;
        o_cfg.units_code       = (r_units > mfe_pkg::UNITS_MAX) ? 4'd0 : r_units;
    end

endmodule

[rtl/core/mfe_frame_core.sv]
module mfe_frame_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mfe_pkg::t_cfg     i_cfg,
    input  logic              i_valid,
    input  mfe_pkg::t_in_item i_in,
    output logic              o_stall,
    output logic              o_res_valid,
    output mfe_pkg::t_res     o_res,
    input  logic              i_res_ready
);

    logic              r_iv;
    mfe_pkg::t_in_item r_in;

    logic              r_folded;
    logic [31:0]       r_crc;
    logic [21:0]       r_off;
    mfe_pkg::t_sec     r_sec;
    logic [18:0]       r_rem;
    logic [16:0]       r_lat_vert;
    logic [18:0]       r_lat_face;
    logic [16:0]       r_lat_color;
    logic [3:0]        r_lat_units;

    logic              adv;
    logic [16:0]       eff_vert;
    logic [18:0]       eff_face;
    logic [16:0]       eff_color;
    logic [3:0]        eff_units;
    logic [63:0]       count_word;
    logic [18:0]       vert_words;
    mfe_pkg::t_sec_pos start_pos;
    logic [31:0]       eff_crc;
    logic [21:0]       eff_off;
    mfe_pkg::t_sec     eff_sec;
    logic [18:0]       eff_rem;
    mfe_pkg::t_sec_pos next_pos;

    logic              n_folded;
    logic [31:0]       n_crc;
    logic [21:0]       n_off;
    mfe_pkg::t_sec     n_sec;
    logic [18:0]       n_rem;

    assign adv         = r_iv && i_res_ready;
    assign o_stall     = r_iv && !i_res_ready;
    assign o_res_valid = adv;

    always_comb begin
        eff_vert   = r_folded ? r_lat_vert  : i_cfg.vertex_triples;
        eff_face   = r_folded ? r_lat_face  : i_cfg.face_word_count;
        eff_color  = r_folded ? r_lat_color : i_cfg.color_word_count;
        eff_units  = r_folded ? r_lat_units : i_cfg.units_code;
        count_word = {13'd0, eff_face, 15'd0, eff_vert};
        vert_words = {1'b0, eff_vert, 1'b0} + {2'b00, eff_vert};
        start_pos  = mfe_pkg::settle(mfe_pkg::SEC_VERT, vert_words, eff_face, eff_color);
        eff_crc    = r_folded ? r_crc : mfe_pkg::crc_fold64(mfe_pkg::CRC_ALL, count_word);
        eff_off    = r_folded ? r_off : mfe_pkg::BODY_DATA_START;
        eff_sec    = r_folded ? r_sec : start_pos.sec;
        eff_rem    = r_folded ? r_rem : start_pos.rem;
        next_pos   = mfe_pkg::settle(eff_sec, eff_rem - 19'd1, eff_face, eff_color);

        n_folded = 1'b1;
        n_crc    = eff_crc;
        n_off    = eff_off;
        n_sec    = eff_sec;
        n_rem    = eff_rem;

        o_res.is_close    = 1'b0;
        o_res.byte_offset = eff_off;
        o_res.out_data    = '0;
        o_res.byte_count  = mfe_pkg::BYTES_NONE;
        o_res.status      = mfe_pkg::ST_OK;
        o_res.has_colors  = (eff_color != 17'd0);
        o_res.units_code  = eff_units;
        o_res.crc         = eff_crc ^ mfe_pkg::CRC_ALL;

        if (r_in.func == mfe_pkg::FUNC_CLOSE) begin
            o_res.is_close    = 1'b1;
            o_res.byte_offset = mfe_pkg::COUNT_WORD_OFF;
            o_res.out_data    = count_word;
            o_res.byte_count  = mfe_pkg::BYTES_WIDE;
            o_res.status      = (eff_sec == mfe_pkg::SEC_DONE) ? mfe_pkg::ST_OK
                                                                : mfe_pkg::ST_SHORT;
            n_folded = 1'b0;
            n_crc    = mfe_pkg::CRC_ALL;
            n_off    = mfe_pkg::BODY_DATA_START;
            n_sec    = mfe_pkg::SEC_VERT;
            n_rem    = '0;
        end else if (eff_sec == mfe_pkg::SEC_DONE) begin
            o_res.status = mfe_pkg::ST_DROP;
        end else if (eff_sec == mfe_pkg::SEC_VERT) begin
            o_res.out_data   = r_in.data_word;
            o_res.byte_count = mfe_pkg::BYTES_WIDE;
            n_crc = mfe_pkg::crc_fold64(eff_crc, r_in.data_word);
            n_off = eff_off + 22'd8;
            n_sec = next_pos.sec;
            n_rem = next_pos.rem;
        end else begin
            o_res.out_data   = {32'd0, r_in.data_word[31:0]};
            o_res.byte_count = mfe_pkg::BYTES_NARROW;
            n_crc = mfe_pkg::crc_fold32(eff_crc, r_in.data_word[31:0]);
            n_off = eff_off + 22'd4;
            n_sec = next_pos.sec;
            n_rem = next_pos.rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv     <= 1'b0;
            r_folded <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_iv <= i_valid;
            end
            if (adv) begin
                r_folded <= n_folded;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_in;
        end
        if (adv) begin
            r_crc <= n_crc;
            r_off <= n_off;
            r_sec <= n_sec;
            r_rem <= n_rem;
            if (!r_folded) begin
                r_lat_vert  <= eff_vert;
                r_lat_face  <= eff_face;
                r_lat_color <= eff_color;
                r_lat_units <= eff_units;
            end
        end
    end

    a_close_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in.func == mfe_pkg::FUNC_CLOSE) |=> !r_folded)
        else $error("frame still open after close");

    a_data_opens_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in.func == mfe_pkg::FUNC_DATA) |=> r_folded)
        else $error("frame not open after data item");

    a_open_section_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_folded && r_sec != mfe_pkg::SEC_DONE) |-> (r_rem != 19'd0))
        else $error("open section with nothing remaining");

    a_offset_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_folded |-> (r_off[1:0] == 2'b00))
        else $error("write offset not word aligned");

endmodule

[rtl/core/mfe_out_stage.sv]
module mfe_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_res_valid,
    input  mfe_pkg::t_res      i_res,
    output logic               o_res_ready,
    output logic               o_valid,
    output mfe_pkg::t_out_item o_out,
    input  logic               i_stall
);

    logic           r_ov;
    mfe_pkg::t_beat r_beat;
    mfe_pkg::t_res  r_res;

    logic           take;
    logic           item_done;
    logic [63:0]    hdr_lo;
    logic [63:0]    hdr_hi;

    assign o_valid     = r_ov;
    assign take        = r_ov && !i_stall;
    assign item_done   = take && (!r_res.is_close || r_beat == mfe_pkg::BEAT_H1);
    assign o_res_ready = !r_ov || item_done;

    always_comb begin
        hdr_lo = {8'h00, (r_res.has_colors ? mfe_pkg::FLAG_COLORS : 8'h00), 8'h00,
                  mfe_pkg::FORMAT_VERSION, mfe_pkg::MAGIC_WORD};
        hdr_hi = {r_res.crc, 28'd0, r_res.units_code};

        o_out.byte_offset = r_res.byte_offset;
        o_out.out_data    = r_res.out_data;
        o_out.byte_count  = r_res.byte_count;
        o_out.last        = 1'b0;
        o_out.status      = r_res.status;
        unique case (r_beat)
            mfe_pkg::BEAT_CW: begin
            end
            mfe_pkg::BEAT_H0: begin
                o_out.byte_offset = mfe_pkg::HEADER_LO_OFF;
                o_out.out_data    = hdr_lo;
                o_out.byte_count  = mfe_pkg::BYTES_WIDE;
            end
            mfe_pkg::BEAT_H1: begin
                o_out.byte_offset = mfe_pkg::HEADER_HI_OFF;
                o_out.out_data    = hdr_hi;
                o_out.byte_count  = mfe_pkg::BYTES_WIDE;
                o_out.last        = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_beat <= mfe_pkg::BEAT_CW;
        end else if (i_res_valid && o_res_ready) begin
            r_ov   <= 1'b1;
            r_beat <= mfe_pkg::BEAT_CW;
        end else if (item_done) begin
            r_ov   <= 1'b0;
            r_beat <= mfe_pkg::BEAT_CW;
        end else if (take) begin
            r_beat <= (r_beat == mfe_pkg::BEAT_CW) ? mfe_pkg::BEAT_H0 : mfe_pkg::BEAT_H1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid && o_res_ready) begin
            r_res <= i_res;
        end
    end

    a_beat_only_on_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_beat != mfe_pkg::BEAT_CW) |-> (r_ov && r_res.is_close))
        else $error("header beat without a close item");

    a_close_keeps_going: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_res.is_close && r_beat != mfe_pkg::BEAT_H1)
        |=> (r_ov && r_beat != mfe_pkg::BEAT_CW))
        else $error("close sequence cut short");

endmodule

[rtl/core/mesh_frame_encoder_crc32.sv]
// mesh frame encoder with crc-32
// input channel: i_valid / o_stall with i_in (func, data_word); an item is taken
// at a clock edge with i_valid high and o_stall low
// output channel: o_valid / i_stall with o_out; a result is taken at an edge with
// o_valid high and i_stall low
// config port: i_cfg_we, i_cfg_idx, i_cfg_data; write only while idle
// latency: a data item's result is on o_out one edge after it is taken
// throughput: one data item per cycle; a close item gives three results
// (count word, header low, header high with last) over three output cycles,
// set by the single output register that sequences them
// crc and offset update for one item are done between the input register
// and the output register in one cycle
// reset: config registers clear, no frame is open, both registers empty
// stall: results hold in the output register; the input register takes one
// more item, then o_stall rises until the output side drains
module mesh_frame_encoder_crc32 (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  mfe_pkg::t_in_item  i_in,
    output logic               o_valid,
    input  logic               i_stall,
    output mfe_pkg::t_out_item o_out,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [18:0]        i_cfg_data
);

    mfe_pkg::t_cfg cfg;
    mfe_pkg::t_res res;
    logic          res_valid;
    logic          res_ready;

    mfe_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    mfe_frame_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_valid),
        .i_in        (i_in),
        .o_stall     (o_stall),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    mfe_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_res_ready (res_ready),
        .o_valid     (o_valid),
        .o_out       (o_out),
        .i_stall     (i_stall)
    );

endmodule
